### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// assertion checked on every rising edge outside reset
`define BRIP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// assertion checked also while reset is held
`define BRIP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BRIP_ASSERT(lbl, clk, rstn, prop, msg)
`define BRIP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### src/brip_pkg.sv
// ----------------------------------------------------------------------------
// brip_pkg
// Relocation kinds, status codes, stage records and field masks.
// ----------------------------------------------------------------------------
package brip_pkg;

  typedef enum logic [3:0] {
    KIND_BR32   = 4'd0,
    KIND_BRCC32 = 4'd1,
    KIND_BAL32  = 4'd2,
    KIND_ABS6   = 4'd3,
    KIND_ABS9   = 4'd4,
    KIND_ABS10  = 4'd5,
    KIND_ABS12  = 4'd6,
    KIND_ABS16  = 4'd7,
    KIND_SHIFT6 = 4'd8,
    KIND_OFF10  = 4'd9,
    KIND_OTHER  = 4'd10
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_OUT_OF_RANGE = 2'd1,
    STATUS_NOT_HANDLED  = 2'd2
  } status_e;

  localparam int unsigned LocW   = 27;
  localparam int unsigned SpaceW = 5;
  localparam int unsigned ValW   = LocW + 1;

  // after the adds
  typedef struct packed {
    logic [3:0]  kind;
    logic        generic;
    logic        over;
    logic        scale;
    logic [31:0] target;
    logic [31:0] site;
    logic [31:0] word;
  } s1_t;

  // after space, distance and word scaling
  typedef struct packed {
    logic [3:0]            kind;
    logic                  generic;
    logic                  bad;
    logic signed [ValW-1:0] val;
    logic [31:0]           word;
  } s2_t;

  function automatic logic [31:0] clear_mask(logic [3:0] kind);
    logic [31:0] m;
    case (kind)
      KIND_BR32:   m = 32'h1fff01ff;
      KIND_BRCC32: m = 32'h1fc001c0;
      KIND_BAL32:  m = 32'h1ff801f8;
      KIND_ABS6:   m = 32'h00070007;
      KIND_ABS9:   m = 32'h1c070007;
      KIND_ABS10:  m = 32'h1e070007;
      KIND_ABS12:  m = 32'h003f003f;
      KIND_ABS16:  m = 32'h1e3f003f;
      KIND_SHIFT6: m = 32'h00070007;
      KIND_OFF10:  m = 32'h1e070007;
      default:     m = 32'h00000000;
    endcase
    return m;
  endfunction

endpackage

### src/brip_insert.sv
// ----------------------------------------------------------------------------
// brip_insert
// Per-kind range check and scatter of the value into the instruction fields.
// ----------------------------------------------------------------------------
module brip_insert import brip_pkg::*; (
  input  logic [3:0]             kind,
  input  logic signed [ValW-1:0] val,
  input  logic [31:0]            word,
  output logic                   fits,
  output logic [31:0]            patched
);

  logic [ValW-1:0] u;
  logic [31:0]     ins;

  always_comb begin
    case (kind)
      KIND_BR32:   fits = (&val[ValW-1:21]) || !(|val[ValW-1:21]);
      KIND_BRCC32: fits = (&val[ValW-1:9])  || !(|val[ValW-1:9]);
      KIND_BAL32:  fits = (&val[ValW-1:17]) || !(|val[ValW-1:17]);
      KIND_OFF10:  fits = (&val[ValW-1:10]) || !(|val[ValW-1:10]);
      KIND_ABS6:   fits = !(|val[ValW-1:6]);
      KIND_ABS9:   fits = !(|val[ValW-1:9]);
      KIND_ABS10:  fits = !(|val[ValW-1:10]);
      KIND_ABS12:  fits = !(|val[ValW-1:12]);
      KIND_ABS16:  fits = (val >= -ValW'(32768)) && (val <= ValW'(65535));
      KIND_SHIFT6: fits = (val >= ValW'(1)) && (val <= ValW'(64));
      default:     fits = 1'b0;
    endcase
  end

  // shift counts are stored minus one
  assign u = (kind == KIND_SHIFT6) ? (val - ValW'(1)) : val;

  always_comb begin
    ins = '0;
    case (kind)
      KIND_BR32: begin
        ins[8:0]   = u[8:0];
        ins[28:16] = u[21:9];
      end
      KIND_BRCC32: begin
        ins[8:6]   = u[2:0];
        ins[28:22] = u[9:3];
      end
      KIND_BAL32: begin
        ins[8:3]   = u[5:0];
        ins[28:19] = u[15:6];
      end
      KIND_ABS6, KIND_SHIFT6: begin
        ins[2:0]   = u[2:0];
        ins[18:16] = u[5:3];
      end
      KIND_ABS9: begin
        ins[2:0]   = u[2:0];
        ins[18:16] = u[5:3];
        ins[28:26] = u[8:6];
      end
      KIND_ABS10, KIND_OFF10: begin
        ins[2:0]   = u[2:0];
        ins[18:16] = u[5:3];
        ins[28:25] = u[9:6];
      end
      KIND_ABS12: begin
        ins[5:0]   = u[5:0];
        ins[21:16] = u[11:6];
      end
      KIND_ABS16: begin
        ins[5:0]   = u[5:0];
        ins[21:16] = u[11:6];
        ins[28:25] = u[15:12];
      end
      default: ins = '0;
    endcase
  end

  assign patched = (word & ~clear_mask(kind)) | ins;

endmodule

### src/branch_and_immediate_reloc_patcher.sv
// ----------------------------------------------------------------------------
// branch_and_immediate_reloc_patcher
// Patches one instruction word for one branch or immediate relocation.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one relocation per beat: kind, symbol value,
//   addend, section base, site offset, section size, the code and debug
//   flags and the original word. The out_ channel returns one beat per
//   input beat, in order: the patched word and a status (ok, out of range,
//   or not handled for generic kinds, which leave the word unchanged).
//   out_valid rises once the beat has passed the stage 1, 2 and 3
//   registers; one beat per cycle is sustained while out_ready is high.
//   Stage 1 does the two 32-bit adds and the section
//   limit compare, stage 2 the space check, site distance and word
//   scaling, stage 3 the range check and field insert into the output
//   register.
//   Each stage holds its beat while the next one is full, so a stall on
//   out_ready backs up stage by stage; bubbles are squeezed out and
//   in_ready drops only when all three stages are full and stalled.
//   Synchronous reset (rst_n low) empties the pipeline; no other state.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module branch_and_immediate_reloc_patcher import brip_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_reloc_kind,
  input  logic [31:0] in_symbol_value,
  input  logic signed [31:0] in_addend,
  input  logic [31:0] in_section_base,
  input  logic [31:0] in_site_offset,
  input  logic [31:0] in_section_size,
  input  logic        in_symbol_in_code,
  input  logic        in_site_in_debug,
  input  logic [31:0] in_original_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_patched_word,
  output logic [1:0]  out_status
);

  logic  s1_v_r, s2_v_r, s3_v_r;
  s1_t   s1_r, s1_nxt;
  s2_t   s2_r, s2_nxt;
  logic  rdy1, rdy2, rdy3;
  logic  [31:0] word_r, word_nxt;
  status_e status_r, status_nxt;

  // stage advance chain
  assign rdy3 = !s3_v_r || out_ready;
  assign rdy2 = !s2_v_r || rdy3;
  assign rdy1 = !s1_v_r || rdy2;
  assign in_ready = rdy1;

  // stage 1: adds and section limit
  always_comb begin
    s1_nxt.kind    = in_reloc_kind;
    s1_nxt.generic = (in_reloc_kind > KIND_OFF10);
    s1_nxt.over    = (in_site_offset > in_section_size);
    s1_nxt.scale   = in_symbol_in_code && !in_site_in_debug;
    s1_nxt.target  = in_symbol_value + in_addend;
    s1_nxt.site    = in_section_base + in_site_offset;
    s1_nxt.word    = in_original_word;
  end

  // stage 2: space, distance, word scaling
  logic                   pcrel;
  logic [SpaceW-1:0]      tspace;
  logic                   space_bad;
  logic signed [ValW-1:0] tloc, sloc, site_dist;
  logic                   odd;

  always_comb begin
    pcrel     = (s1_r.kind == KIND_BR32) || (s1_r.kind == KIND_BRCC32) ||
                (s1_r.kind == KIND_BAL32);
    tspace    = s1_r.target[31:LocW];
    space_bad = pcrel && (tspace != '0) && (tspace != s1_r.site[31:LocW]);
    tloc      = {1'b0, s1_r.target[LocW-1:0]};
    sloc      = {1'b0, s1_r.site[LocW-1:0]};
    site_dist = pcrel ? (tloc - sloc) : tloc;
    odd       = s1_r.scale && (site_dist[0] || sloc[0]);
    s2_nxt.kind    = s1_r.kind;
    s2_nxt.generic = s1_r.generic;
    s2_nxt.bad     = s1_r.over || space_bad || odd;
    s2_nxt.val     = s1_r.scale ? (site_dist >>> 1) : site_dist;
    s2_nxt.word    = s1_r.word;
  end

  // stage 3: range check and insert
  logic        fits;
  logic [31:0] patched;

  brip_insert u_insert (
    .kind    (s2_r.kind),
    .val     (s2_r.val),
    .word    (s2_r.word),
    .fits    (fits),
    .patched (patched)
  );

  always_comb begin
    if (s2_r.generic) begin
      status_nxt = STATUS_NOT_HANDLED;
    end else if (s2_r.bad || !fits) begin
      status_nxt = STATUS_OUT_OF_RANGE;
    end else begin
      status_nxt = STATUS_OK;
    end
    word_nxt = (status_nxt == STATUS_OK) ? patched : s2_r.word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_r <= in_valid;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_r <= s1_nxt;
    end
    if (rdy2 && s1_v_r) begin
      s2_r <= s2_nxt;
    end
    if (rdy3 && s2_v_r) begin
      word_r   <= word_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid        = s3_v_r;
  assign out_patched_word = word_r;
  assign out_status       = status_r;

  `BRIP_ASSERT(a_full_stall_blocks, clk, rst_n, (s1_v_r && s2_v_r && s3_v_r && !out_ready) |-> !in_ready, "full stalled pipeline still takes beats")
  `BRIP_ASSERT(a_out_from_s2, clk, rst_n, $rose(out_valid) |-> $past(s2_v_r), "output beat appeared without a stage 2 beat")
  `BRIP_ASSERT(a_generic_status, clk, rst_n, (s2_v_r && rdy3 && (s2_r.kind > KIND_OFF10)) |=> (out_status == STATUS_NOT_HANDLED), "generic kind not reported as not handled")
  `BRIP_ASSERT(a_bad_never_ok, clk, rst_n, (s2_v_r && rdy3 && s2_r.bad) |=> (out_status != STATUS_OK), "failed site check reported ok")

endmodule
